/* rtl/sbct_pkg.sv */
package sbct_pkg;

    localparam int SLOTS = 128;
    localparam int SLOT_W = 7;

    typedef enum logic [1:0] {
        ACT_POS  = 2'd0,
        ACT_BOX  = 2'd1,
        ACT_TEST = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_LATB,
        ST_VEC,
        ST_AXIS,
        ST_PROJ,
        ST_CMP,
        ST_DONE,
        ST_CLEAR
    } state_t;

    // one stored sprite entry
    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
        logic [11:0]        bw;
        logic [11:0]        bh;
        logic [7:0]         grp;
        logic               on;
    } entry_t;

endpackage

/* rtl/swept_box_collision_test_top.sv */
// test item: two table reads and a set-up step, then done when a sprite is off or no group
// is shared; else, per axis tested (one to three), one set-up step, four vertex steps through
// the shared projection unit and a compare, then done
// items: one at a time; start is taken only while busy is low
// reset: asynchronous, active low; afterwards a clearing pass
// zeroes the sprite table while busy stays high; the receiver cannot stall
module swept_box_collision_test_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          action,
    input  logic [6:0]          slot,
    input  logic [6:0]          other_slot,
    input  logic signed [15:0]  x_pos,
    input  logic signed [15:0]  y_pos,
    input  logic signed [15:0]  delta_x,
    input  logic signed [15:0]  delta_y,
    input  logic [11:0]         box_w,
    input  logic [11:0]         box_h,
    input  logic [7:0]          group_mask,
    input  logic                active,
    output logic                done,
    output logic                hit,
    output logic [6:0]          tested_slot
);

    sbct_pkg::state_t state_reg, state_next;
    sbct_pkg::entry_t mem [sbct_pkg::SLOTS];
    sbct_pkg::entry_t rd_reg;
    sbct_pkg::entry_t ea_reg, eb_reg;

    logic [sbct_pkg::SLOT_W:0]   clr_reg, clr_next;
    logic [sbct_pkg::SLOT_W-1:0] a_reg, b_reg;
    logic [1:0]                  axis_reg, axis_next;
    logic [1:0]                  vtx_reg, vtx_next;
    logic signed [17:0]          rx_reg, ry_reg;
    logic signed [17:0]          nx_reg, ny_reg;
    logic signed [40:0]          amin_reg, amax_reg, bmin_reg, bmax_reg;
    logic                        hit_reg, hit_next;
    logic                        done_reg;
    logic                        ovl;

    logic start_ok;
    assign start_ok = start && !busy;

    // table: one write port, one registered read port
    logic                        we;
    logic [sbct_pkg::SLOT_W-1:0] waddr, raddr;

    always_comb
    begin
        we    = 1'b0;
        waddr = slot;
        raddr = a_reg;
        if (state_reg == sbct_pkg::ST_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg[sbct_pkg::SLOT_W-1:0];
        end
        else if (state_reg == sbct_pkg::ST_IDLE && start_ok)
        begin
            waddr = slot;
            if (action == sbct_pkg::ACT_POS || action == sbct_pkg::ACT_BOX)
                we = 1'b1;
        end
        if (state_reg == sbct_pkg::ST_RDB)
            raddr = b_reg;
    end

    // write items update only their own fields of the entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            if (state_reg == sbct_pkg::ST_CLEAR)
                mem[waddr] <= '0;
            else if (action == sbct_pkg::ACT_POS)
            begin
                mem[waddr].px <= x_pos;
                mem[waddr].py <= y_pos;
                mem[waddr].mx <= delta_x;
                mem[waddr].my <= delta_y;
            end
            else
            begin
                mem[waddr].hx  <= delta_x;
                mem[waddr].hy  <= delta_y;
                mem[waddr].bw  <= box_w;
                mem[waddr].bh  <= box_h;
                mem[waddr].grp <= group_mask;
                mem[waddr].on  <= active;
            end
        end
        rd_reg <= mem[raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            sbct_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (sbct_pkg::SLOT_W+1)'(sbct_pkg::SLOTS - 1))
                    state_next = sbct_pkg::ST_IDLE;
            end
            sbct_pkg::ST_IDLE:
                if (start_ok && action == sbct_pkg::ACT_TEST)
                    state_next = sbct_pkg::ST_RDA;
            sbct_pkg::ST_RDA:  state_next = sbct_pkg::ST_RDB;
            sbct_pkg::ST_RDB:  state_next = sbct_pkg::ST_LATB;
            sbct_pkg::ST_LATB: state_next = sbct_pkg::ST_VEC;
            sbct_pkg::ST_VEC:
                if (!ea_reg.on || !eb_reg.on || (ea_reg.grp & eb_reg.grp) == 8'd0)
                    state_next = sbct_pkg::ST_DONE;
                else
                    state_next = sbct_pkg::ST_AXIS;
            sbct_pkg::ST_AXIS: state_next = sbct_pkg::ST_PROJ;
            sbct_pkg::ST_PROJ:
                if (vtx_reg == 2'd3)
                    state_next = sbct_pkg::ST_CMP;
            sbct_pkg::ST_CMP:
                if (!ovl || axis_reg == 2'd2 || (axis_reg == 2'd1 && rx_reg == '0
                    && ry_reg == '0))
                    state_next = sbct_pkg::ST_DONE;
                else
                    state_next = sbct_pkg::ST_AXIS;
            sbct_pkg::ST_DONE: state_next = sbct_pkg::ST_IDLE;
            default:           state_next = sbct_pkg::ST_IDLE;
        endcase
    end

    // shared projection unit: one vertex corner of a, swept a and b per cycle
    logic signed [17:0] pax, pay, pbx, pby;
    logic signed [35:0] m_ax, m_ay, m_bx, m_by, m_rx, m_ry;
    logic signed [40:0] da, ds, db;
    logic signed [40:0] lo_a, hi_a;

    always_comb
    begin
        pax = 18'(ea_reg.px) + ((vtx_reg == 2'd1 || vtx_reg == 2'd2)
              ? 18'(signed'({1'b0, ea_reg.bw})) : 18'sd0);
        pay = 18'(ea_reg.py) + ((vtx_reg[1])
              ? 18'(signed'({1'b0, ea_reg.bh})) : 18'sd0);
        pbx = 18'(eb_reg.px) + ((vtx_reg == 2'd1 || vtx_reg == 2'd2)
              ? 18'(signed'({1'b0, eb_reg.bw})) : 18'sd0);
        pby = 18'(eb_reg.py) + ((vtx_reg[1])
              ? 18'(signed'({1'b0, eb_reg.bh})) : 18'sd0);
        m_ax = nx_reg * pax;
        m_ay = ny_reg * pay;
        m_bx = nx_reg * pbx;
        m_by = ny_reg * pby;
        m_rx = nx_reg * rx_reg;
        m_ry = ny_reg * ry_reg;
        da = 41'(m_ax) + 41'(m_ay);
        db = 41'(m_bx) + 41'(m_by);
        ds = da + 41'(m_rx) + 41'(m_ry);
        lo_a = (da < ds) ? da : ds;
        hi_a = (da < ds) ? ds : da;
        ovl  = (amin_reg <= bmax_reg) && (amax_reg >= bmin_reg);
    end

    always_comb
    begin
        axis_next = axis_reg;
        vtx_next  = vtx_reg;
        hit_next  = hit_reg;
        case (state_reg)
            sbct_pkg::ST_VEC:  begin axis_next = 2'd0; hit_next = 1'b0; end
            sbct_pkg::ST_AXIS: vtx_next = 2'd0;
            sbct_pkg::ST_PROJ: vtx_next = vtx_reg + 2'd1;
            sbct_pkg::ST_CMP:
            begin
                axis_next = axis_reg + 2'd1;
                if (!ovl)
                    hit_next = 1'b0;
                else if (state_next == sbct_pkg::ST_DONE)
                    hit_next = 1'b1;
            end
            default: ;
        endcase
    end

    // collision vectors and axis set-up
    logic signed [15:0] cax, cay, cbx, cby;
    always_comb
    begin
        cax = (ea_reg.hx == '0 && ea_reg.hy == '0) ? ea_reg.mx : ea_reg.hx;
        cay = (ea_reg.hx == '0 && ea_reg.hy == '0) ? ea_reg.my : ea_reg.hy;
        cbx = (eb_reg.hx == '0 && eb_reg.hy == '0) ? eb_reg.mx : eb_reg.hx;
        cby = (eb_reg.hx == '0 && eb_reg.hy == '0) ? eb_reg.my : eb_reg.hy;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sbct_pkg::ST_IDLE && start_ok)
        begin
            a_reg <= slot;
            b_reg <= other_slot;
        end
        if (state_reg == sbct_pkg::ST_RDB)
            ea_reg <= rd_reg;
        if (state_reg == sbct_pkg::ST_LATB)
            eb_reg <= rd_reg;
        if (state_reg == sbct_pkg::ST_VEC)
        begin
            rx_reg <= 18'(cax) - 18'(cbx);
            ry_reg <= 18'(cay) - 18'(cby);
        end
        if (state_reg == sbct_pkg::ST_AXIS)
        begin
            case (axis_reg)
                2'd0:    begin nx_reg <= 18'sd1; ny_reg <= 18'sd0; end
                2'd1:    begin nx_reg <= 18'sd0; ny_reg <= 18'sd1; end
                default: begin nx_reg <= -ry_reg; ny_reg <= rx_reg; end
            endcase
        end
        if (state_reg == sbct_pkg::ST_PROJ)
        begin
            if (vtx_reg == 2'd0)
            begin
                amin_reg <= lo_a; amax_reg <= hi_a;
                bmin_reg <= db;   bmax_reg <= db;
            end
            else
            begin
                if (lo_a < amin_reg) amin_reg <= lo_a;
                if (hi_a > amax_reg) amax_reg <= hi_a;
                if (db < bmin_reg)   bmin_reg <= db;
                if (db > bmax_reg)   bmax_reg <= db;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbct_pkg::ST_CLEAR;
            clr_reg   <= '0;
            axis_reg  <= '0;
            vtx_reg   <= '0;
            hit_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            axis_reg  <= axis_next;
            vtx_reg   <= vtx_next;
            hit_reg   <= hit_next;
            done_reg  <= (state_reg == sbct_pkg::ST_DONE);
        end
    end

    // outputs
    always_comb
    begin
        busy        = (state_reg != sbct_pkg::ST_IDLE) || done_reg;
        done        = done_reg;
        hit         = hit_reg;
        tested_slot = a_reg;
    end

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbct_pkg::ST_CLEAR) |-> busy) else $error("idle during clear");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == sbct_pkg::ST_DONE) else $error("stray done");
`endif

endmodule

/* tb/sv/swept_box_collision_test_top_test.sv */
module swept_box_collision_test_top_test;

    // one command to the sprite table
    typedef struct {
        sbct_pkg::action_t  act;
        logic [6:0]         slot;
        logic [6:0]         other;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [11:0]        w;
        logic [11:0]        h;
        logic [7:0]         grp;
        logic               on;
    } sprite_cmd_t;

    typedef struct {
        logic       hit;
        logic [6:0] slot;
    } verdict_t;

    // sprite table copy and the verdicts still due
    class collision_board;
        longint px[sbct_pkg::SLOTS], py[sbct_pkg::SLOTS];
        longint mx[sbct_pkg::SLOTS], my[sbct_pkg::SLOTS];
        longint hx[sbct_pkg::SLOTS], hy[sbct_pkg::SLOTS];
        longint bw[sbct_pkg::SLOTS], bh[sbct_pkg::SLOTS];
        bit [7:0] grp[sbct_pkg::SLOTS];
        bit on[sbct_pkg::SLOTS];
        verdict_t pending_verdicts[$];

        function void clear_table();
            for (int i = 0; i < sbct_pkg::SLOTS; i++)
            begin
                px[i] = 0; py[i] = 0; mx[i] = 0; my[i] = 0;
                hx[i] = 0; hy[i] = 0; bw[i] = 0; bh[i] = 0;
                grp[i] = 0; on[i] = 0;
            end
            pending_verdicts.delete();
        endfunction

        // closed-range overlap of the projections on one axis
        function bit ranges_meet(longint nx, longint ny, longint ax[8], longint ay[8],
                                 longint bx[4], longint by[4]);
            longint d, amin, amax, bmin, bmax;
            for (int i = 0; i < 4; i++)
            begin
                d = nx * bx[i] + ny * by[i];
                if (i == 0 || d < bmin) bmin = d;
                if (i == 0 || d > bmax) bmax = d;
            end
            for (int i = 0; i < 8; i++)
            begin
                d = nx * ax[i] + ny * ay[i];
                if (i == 0 || d < amin) amin = d;
                if (i == 0 || d > amax) amax = d;
            end
            return amin <= bmax && amax >= bmin;
        endfunction

        function bit sprites_collide(int a, int b);
            longint ax[8], ay[8], bx[4], by[4];
            longint cax, cay, cbx, cby, rx, ry;
            if (!on[a] || !on[b]) return 0;
            if ((grp[a] & grp[b]) == 0) return 0;
            // hit vector wins unless it is zero
            if (hx[a] == 0 && hy[a] == 0) begin cax = mx[a]; cay = my[a]; end
            else begin cax = hx[a]; cay = hy[a]; end
            if (hx[b] == 0 && hy[b] == 0) begin cbx = mx[b]; cby = my[b]; end
            else begin cbx = hx[b]; cby = hy[b]; end
            rx = cax - cbx;
            ry = cay - cby;
            // box a at rest and swept, box b at rest
            for (int k = 0; k < 2; k++)
            begin
                longint ox, oy;
                ox = px[a] + (k ? rx : 0);
                oy = py[a] + (k ? ry : 0);
                ax[4*k]   = ox;         ay[4*k]   = oy;
                ax[4*k+1] = ox + bw[a]; ay[4*k+1] = oy;
                ax[4*k+2] = ox + bw[a]; ay[4*k+2] = oy + bh[a];
                ax[4*k+3] = ox;         ay[4*k+3] = oy + bh[a];
            end
            bx[0] = px[b];         by[0] = py[b];
            bx[1] = px[b] + bw[b]; by[1] = py[b];
            bx[2] = px[b] + bw[b]; by[2] = py[b] + bh[b];
            bx[3] = px[b];         by[3] = py[b] + bh[b];
            if (!ranges_meet(1, 0, ax, ay, bx, by)) return 0;
            if (!ranges_meet(0, 1, ax, ay, bx, by)) return 0;
            if (rx != 0 || ry != 0)
            begin
                if (!ranges_meet(-ry, rx, ax, ay, bx, by)) return 0;
            end
            return 1;
        endfunction

        // apply an accepted item
        function void note_item(sprite_cmd_t c);
            verdict_t v;
            int s;
            s = c.slot;
            case (c.act)
                sbct_pkg::ACT_POS:
                begin
                    px[s] = c.x; py[s] = c.y; mx[s] = c.dx; my[s] = c.dy;
                end
                sbct_pkg::ACT_BOX:
                begin
                    hx[s] = c.dx; hy[s] = c.dy; bw[s] = c.w; bh[s] = c.h;
                    grp[s] = c.grp; on[s] = c.on;
                end
                sbct_pkg::ACT_TEST:
                begin
                    v.hit = sprites_collide(s, c.other);
                    v.slot = c.slot;
                    pending_verdicts = {pending_verdicts, v};
                end
                default: ;
            endcase
        endfunction

        // returns an empty string when the result is as predicted
        function string check_result(logic hit_o, logic [6:0] slot_o);
            verdict_t v;
            string msg;
            msg = "";
            if (pending_verdicts.size() == 0)
                return $sformatf("unexpected result hit=%0d slot=%0d", hit_o, slot_o);
            v = pending_verdicts.pop_front();
            if (hit_o !== v.hit)
                msg = $sformatf("hit %0d, predicted %0d (slot %0d)", hit_o, v.hit, v.slot);
            if (slot_o !== v.slot)
                msg = {msg, $sformatf(" tested_slot %0d, predicted %0d", slot_o, v.slot)};
            return msg;
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         action = 2'd0;
    logic [6:0]         slot = 7'd0;
    logic [6:0]         other_slot = 7'd0;
    logic signed [15:0] x_pos = 16'sd0;
    logic signed [15:0] y_pos = 16'sd0;
    logic signed [15:0] delta_x = 16'sd0;
    logic signed [15:0] delta_y = 16'sd0;
    logic [11:0]        box_w = 12'd0;
    logic [11:0]        box_h = 12'd0;
    logic [7:0]         group_mask = 8'd0;
    logic               active = 1'b0;
    logic               done;
    logic               hit;
    logic [6:0]         tested_slot;

    collision_board board = new();
    int mismatches = 0;
    bit burst_mode = 0;

    swept_box_collision_test_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .slot(slot), .other_slot(other_slot),
        .x_pos(x_pos), .y_pos(y_pos), .delta_x(delta_x), .delta_y(delta_y),
        .box_w(box_w), .box_h(box_h), .group_mask(group_mask), .active(active),
        .done(done), .hit(hit), .tested_slot(tested_slot)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // result monitor, sampled mid-cycle while the strobe is stable
    always @(negedge clk)
    begin
        string msg;
        if (rst_n && done)
        begin
            msg = board.check_result(hit, tested_slot);
            if (msg != "") report_mismatch(msg);
        end
    end

    // present one item, hold it until taken, then maybe idle
    task send_item(sprite_cmd_t c);
        int gap;
        bit took;
        start <= 1'b1;
        action <= c.act; slot <= c.slot; other_slot <= c.other;
        x_pos <= c.x; y_pos <= c.y; delta_x <= c.dx; delta_y <= c.dy;
        box_w <= c.w; box_h <= c.h; group_mask <= c.grp; active <= c.on;
        // busy only moves at rising edges, so its mid-cycle value decides the next edge
        do
        begin
            @(negedge clk);
            took = !busy;
            @(posedge clk);
        end
        while (!took);
        board.note_item(c);
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function sprite_cmd_t make_cmd(sbct_pkg::action_t a, int s, int o);
        sprite_cmd_t c;
        c.act = a; c.slot = 7'(s); c.other = 7'(o);
        c.x = 16'($urandom); c.y = 16'($urandom);
        c.dx = 16'($urandom); c.dy = 16'($urandom);
        c.w = 12'($urandom); c.h = 12'($urandom);
        c.grp = 8'($urandom); c.on = 1'($urandom);
        return c;
    endfunction

    // mostly small coordinates so boxes meet, sometimes full range
    function logic signed [15:0] coord();
        if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 1600)) - 800);
        return 16'($urandom);
    endfunction

    function sprite_cmd_t random_cmd();
        sprite_cmd_t c;
        int r, pool;
        r = $urandom_range(0, 99);
        pool = ($urandom_range(0, 9) < 8) ? 7 : 127;
        c = make_cmd(r < 30 ? sbct_pkg::ACT_POS : r < 55 ? sbct_pkg::ACT_BOX :
                     r < 95 ? sbct_pkg::ACT_TEST : sbct_pkg::ACT_NONE,
                     $urandom_range(0, pool), $urandom_range(0, pool));
        c.x = coord(); c.y = coord();
        if ($urandom_range(0, 3) == 0) begin c.dx = 16'sd0; c.dy = 16'sd0; end
        else begin c.dx = coord(); c.dy = coord(); end
        if ($urandom_range(0, 9) < 8)
        begin
            c.w = 12'($urandom_range(0, 400));
            c.h = 12'($urandom_range(0, 400));
        end
        if ($urandom_range(0, 9) < 7) c.grp = 8'h01 << $urandom_range(0, 7) | 8'h80;
        c.on = ($urandom_range(0, 9) < 8);
        return c;
    endfunction

    // stimulus
    initial
    begin
        sprite_cmd_t c;
        board.clear_table();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, each action, special cases
        c = make_cmd(sbct_pkg::ACT_TEST, 0, 1);   send_item(c); // table still clear
        c = make_cmd(sbct_pkg::ACT_POS, 0, 0);
        c.x = 16'sh8000; c.y = 16'sh7fff; c.dx = 16'sh7fff; c.dy = 16'sh8000;
        send_item(c);
        c = make_cmd(sbct_pkg::ACT_BOX, 0, 0);
        c.dx = 16'sd0; c.dy = 16'sd0; c.w = 12'hfff; c.h = 12'hfff;
        c.grp = 8'hff; c.on = 1'b1;
        send_item(c);
        c = make_cmd(sbct_pkg::ACT_POS, 127, 0);
        c.x = 16'sh7fff; c.y = 16'sh8000; c.dx = 16'sh8000; c.dy = 16'sh7fff;
        send_item(c);
        c = make_cmd(sbct_pkg::ACT_BOX, 127, 0);
        c.dx = 16'sh7fff; c.dy = 16'sh8000; c.w = 12'd0; c.h = 12'd0;
        c.grp = 8'h01; c.on = 1'b1;
        send_item(c);
        c = make_cmd(sbct_pkg::ACT_TEST, 0, 127); send_item(c);
        c = make_cmd(sbct_pkg::ACT_TEST, 127, 0); send_item(c);
        c = make_cmd(sbct_pkg::ACT_TEST, 0, 0);   send_item(c); // same slot twice
        // overlapping pair with zero relative motion
        c = make_cmd(sbct_pkg::ACT_POS, 1, 0);
        c.x = 16'sd0; c.y = 16'sd0; c.dx = 16'sd16; c.dy = 16'sd16;  send_item(c);
        c = make_cmd(sbct_pkg::ACT_POS, 2, 0);
        c.x = 16'sd8; c.y = 16'sd8; c.dx = 16'sd16; c.dy = 16'sd16;  send_item(c);
        c = make_cmd(sbct_pkg::ACT_BOX, 1, 0);
        c.dx = 16'sd0; c.dy = 16'sd0; c.w = 12'd32; c.h = 12'd32;
        c.grp = 8'h02; c.on = 1'b1;
        send_item(c);
        c = make_cmd(sbct_pkg::ACT_BOX, 2, 0);
        c.dx = 16'sd0; c.dy = 16'sd0; c.w = 12'd32; c.h = 12'd32;
        c.grp = 8'h06; c.on = 1'b1;
        send_item(c);
        c = make_cmd(sbct_pkg::ACT_TEST, 1, 2);   send_item(c);
        // no common group
        c = make_cmd(sbct_pkg::ACT_BOX, 2, 0);
        c.dx = 16'sd0; c.dy = 16'sd0; c.w = 12'd32; c.h = 12'd32;
        c.grp = 8'h04; c.on = 1'b1;
        send_item(c);
        c = make_cmd(sbct_pkg::ACT_TEST, 1, 2);   send_item(c);
        // inactive second sprite
        c = make_cmd(sbct_pkg::ACT_BOX, 2, 0);
        c.dx = 16'sd0; c.dy = 16'sd0; c.w = 12'd32; c.h = 12'd32;
        c.grp = 8'hff; c.on = 1'b0;
        send_item(c);
        c = make_cmd(sbct_pkg::ACT_TEST, 1, 2);   send_item(c);
        // unused action
        c = make_cmd(sbct_pkg::ACT_NONE, 3, 4);   send_item(c);
        c = make_cmd(sbct_pkg::ACT_TEST, 2, 1);   send_item(c);

        // hold off until the table is quiet
        while (board.pending_verdicts.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);

        // random part with stretches of back-to-back items
        for (int n = 0; n < 1850; n++)
        begin
            if (n % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            send_item(random_cmd());
        end
        start <= 1'b0;

        while (board.pending_verdicts.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("swept_box_collision_test_top_test: PASS");
        else
            $display("swept_box_collision_test_top_test: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("swept_box_collision_test_top_test: FAIL");
        $finish;
    end

endmodule
